### design/touch_calibration_affine_fit_top_assert.svh
`ifndef TOUCH_CALIBRATION_AFFINE_FIT_TOP_ASSERT_SVH
`define TOUCH_CALIBRATION_AFFINE_FIT_TOP_ASSERT_SVH
// same-cycle implication, clocked on clk, off during reset
`define TCAF_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("tcaf: same-cycle check failed");
// next-cycle implication
`define TCAF_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("tcaf: next-cycle check failed");
`endif

### design/tcaf_pkg.sv
package tcaf_pkg;

	localparam int FIELD_BITS = 12;
	localparam int RAW_MAX    = 16;
	localparam int NREGS      = 17;

	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_TARGET_MARGIN = 2'd2;

	// register file slots
	localparam logic [4:0] R_N   = 5'd0;
	localparam logic [4:0] R_SX  = 5'd1;
	localparam logic [4:0] R_SY  = 5'd2;
	localparam logic [4:0] R_SXX = 5'd3;
	localparam logic [4:0] R_SYY = 5'd4;
	localparam logic [4:0] R_SXY = 5'd5;
	localparam logic [4:0] R_A   = 5'd6;
	localparam logic [4:0] R_B   = 5'd7;
	localparam logic [4:0] R_C   = 5'd8;
	localparam logic [4:0] R_E   = 5'd9;
	localparam logic [4:0] R_F   = 5'd10;
	localparam logic [4:0] R_I   = 5'd11;
	localparam logic [4:0] R_DET = 5'd12;
	localparam logic [4:0] R_Z   = 5'd13;
	localparam logic [4:0] R_ZX  = 5'd14;
	localparam logic [4:0] R_ZY  = 5'd15;
	localparam logic [4:0] R_NUM = 5'd16;

	// per-point term operand selects
	localparam logic [4:0] SEL_ONE = 5'd0;
	localparam logic [4:0] SEL_RX  = 5'd1;
	localparam logic [4:0] SEL_RY  = 5'd2;
	localparam logic [4:0] SEL_TX  = 5'd3;
	localparam logic [4:0] SEL_TY  = 5'd4;

	localparam logic [6:0] PROG_LAST = 7'd77;

	typedef enum logic [2:0] {
		OP_SUMPT,
		OP_MUL,
		OP_STORE,
		OP_ZCHK,
		OP_DIV,
		OP_END
	} op_t;

	typedef enum logic [1:0] {
		ACC_SET,
		ACC_ADD,
		ACC_SUB
	} acc_mode_t;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_DISPATCH,
		ST_START,
		ST_BUSY,
		ST_ACCUM,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t       op;
		acc_mode_t mode;
		logic [4:0] a;
		logic [4:0] b;
		logic [4:0] d;
	} instr_t;

	typedef struct packed {
		logic [11:0] screen_width;
		logic [11:0] screen_height;
		logic [9:0]  target_margin;
	} cfg_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] raw_x;
		logic [FIELD_BITS-1:0] raw_y;
	} touch_t;

	typedef struct packed {
		logic               fit_ok;
		logic signed [31:0] xs_offset;
		logic signed [31:0] xs_from_rx;
		logic signed [31:0] xs_from_ry;
		logic signed [31:0] ys_offset;
		logic signed [31:0] ys_from_rx;
		logic signed [31:0] ys_from_ry;
		logic [16:0]        scale_value;
	} fit_t;

	typedef struct packed {
		logic       store_pt;
		logic [2:0] pt_idx;
		logic [4:0] rd_a;
		logic [4:0] rd_b;
		logic       term_go;
		logic       mul_start;
		logic       div_start;
		logic       acc_go;
		acc_mode_t  acc_mode;
		logic       wr_en;
		logic [4:0] wr_addr;
		logic [2:0] coef_idx;
		logic       out_load;
		logic       out_ok;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic acc_zero;
	} dp_sts_t;

	function automatic instr_t mk(op_t op, acc_mode_t mode, logic [4:0] a, logic [4:0] b,
		logic [4:0] d);
		instr_t r;
		r.op = op;
		r.mode = mode;
		r.a = a;
		r.b = b;
		r.d = d;
		return r;
	endfunction

	// fit sequence; MUL multiplies a by b, iterating over the bits of b
	function automatic instr_t prog_at(logic [6:0] pc);
		instr_t r;
		unique case (pc)
			7'd0:  r = mk(OP_SUMPT, ACC_SET, SEL_ONE, SEL_ONE, R_N);
			7'd1:  r = mk(OP_STORE, ACC_SET, R_N, R_N, R_N);
			7'd2:  r = mk(OP_SUMPT, ACC_SET, SEL_RX, SEL_ONE, R_N);
			7'd3:  r = mk(OP_STORE, ACC_SET, R_N, R_N, R_SX);
			7'd4:  r = mk(OP_SUMPT, ACC_SET, SEL_RY, SEL_ONE, R_N);
			7'd5:  r = mk(OP_STORE, ACC_SET, R_N, R_N, R_SY);
			7'd6:  r = mk(OP_SUMPT, ACC_SET, SEL_RX, SEL_RX, R_N);
			7'd7:  r = mk(OP_STORE, ACC_SET, R_N, R_N, R_SXX);
			7'd8:  r = mk(OP_SUMPT, ACC_SET, SEL_RY, SEL_RY, R_N);
			7'd9:  r = mk(OP_STORE, ACC_SET, R_N, R_N, R_SYY);
			7'd10: r = mk(OP_SUMPT, ACC_SET, SEL_RX, SEL_RY, R_N);
			7'd11: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_SXY);
			7'd12: r = mk(OP_MUL, ACC_SET, R_SXX, R_SYY, R_N);
			7'd13: r = mk(OP_MUL, ACC_SUB, R_SXY, R_SXY, R_N);
			7'd14: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_A);
			7'd15: r = mk(OP_MUL, ACC_SET, R_SXY, R_SY, R_N);
			7'd16: r = mk(OP_MUL, ACC_SUB, R_SYY, R_SX, R_N);
			7'd17: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_B);
			7'd18: r = mk(OP_MUL, ACC_SET, R_SXY, R_SX, R_N);
			7'd19: r = mk(OP_MUL, ACC_SUB, R_SXX, R_SY, R_N);
			7'd20: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_C);
			7'd21: r = mk(OP_MUL, ACC_SET, R_SYY, R_N, R_N);
			7'd22: r = mk(OP_MUL, ACC_SUB, R_SY, R_SY, R_N);
			7'd23: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_E);
			7'd24: r = mk(OP_MUL, ACC_SET, R_SX, R_SY, R_N);
			7'd25: r = mk(OP_MUL, ACC_SUB, R_SXY, R_N, R_N);
			7'd26: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_F);
			7'd27: r = mk(OP_MUL, ACC_SET, R_SXX, R_N, R_N);
			7'd28: r = mk(OP_MUL, ACC_SUB, R_SX, R_SX, R_N);
			7'd29: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_I);
			7'd30: r = mk(OP_MUL, ACC_SET, R_A, R_N, R_N);
			7'd31: r = mk(OP_MUL, ACC_ADD, R_B, R_SX, R_N);
			7'd32: r = mk(OP_MUL, ACC_ADD, R_C, R_SY, R_N);
			7'd33: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_DET);
			7'd34: r = mk(OP_ZCHK, ACC_SET, R_N, R_N, R_N);
			7'd35: r = mk(OP_SUMPT, ACC_SET, SEL_TX, SEL_ONE, R_N);
			7'd36: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_Z);
			7'd37: r = mk(OP_SUMPT, ACC_SET, SEL_TX, SEL_RX, R_N);
			7'd38: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_ZX);
			7'd39: r = mk(OP_SUMPT, ACC_SET, SEL_TX, SEL_RY, R_N);
			7'd40: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_ZY);
			7'd41: r = mk(OP_MUL, ACC_SET, R_A, R_Z, R_N);
			7'd42: r = mk(OP_MUL, ACC_ADD, R_B, R_ZX, R_N);
			7'd43: r = mk(OP_MUL, ACC_ADD, R_C, R_ZY, R_N);
			7'd44: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_NUM);
			7'd45: r = mk(OP_DIV, ACC_SET, R_NUM, R_DET, 5'd0);
			7'd46: r = mk(OP_MUL, ACC_SET, R_B, R_Z, R_N);
			7'd47: r = mk(OP_MUL, ACC_ADD, R_E, R_ZX, R_N);
			7'd48: r = mk(OP_MUL, ACC_ADD, R_F, R_ZY, R_N);
			7'd49: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_NUM);
			7'd50: r = mk(OP_DIV, ACC_SET, R_NUM, R_DET, 5'd1);
			7'd51: r = mk(OP_MUL, ACC_SET, R_C, R_Z, R_N);
			7'd52: r = mk(OP_MUL, ACC_ADD, R_F, R_ZX, R_N);
			7'd53: r = mk(OP_MUL, ACC_ADD, R_I, R_ZY, R_N);
			7'd54: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_NUM);
			7'd55: r = mk(OP_DIV, ACC_SET, R_NUM, R_DET, 5'd2);
			7'd56: r = mk(OP_SUMPT, ACC_SET, SEL_TY, SEL_ONE, R_N);
			7'd57: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_Z);
			7'd58: r = mk(OP_SUMPT, ACC_SET, SEL_TY, SEL_RX, R_N);
			7'd59: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_ZX);
			7'd60: r = mk(OP_SUMPT, ACC_SET, SEL_TY, SEL_RY, R_N);
			7'd61: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_ZY);
			7'd62: r = mk(OP_MUL, ACC_SET, R_A, R_Z, R_N);
			7'd63: r = mk(OP_MUL, ACC_ADD, R_B, R_ZX, R_N);
			7'd64: r = mk(OP_MUL, ACC_ADD, R_C, R_ZY, R_N);
			7'd65: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_NUM);
			7'd66: r = mk(OP_DIV, ACC_SET, R_NUM, R_DET, 5'd3);
			7'd67: r = mk(OP_MUL, ACC_SET, R_B, R_Z, R_N);
			7'd68: r = mk(OP_MUL, ACC_ADD, R_E, R_ZX, R_N);
			7'd69: r = mk(OP_MUL, ACC_ADD, R_F, R_ZY, R_N);
			7'd70: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_NUM);
			7'd71: r = mk(OP_DIV, ACC_SET, R_NUM, R_DET, 5'd4);
			7'd72: r = mk(OP_MUL, ACC_SET, R_C, R_Z, R_N);
			7'd73: r = mk(OP_MUL, ACC_ADD, R_F, R_ZX, R_N);
			7'd74: r = mk(OP_MUL, ACC_ADD, R_I, R_ZY, R_N);
			7'd75: r = mk(OP_STORE, ACC_SET, R_N, R_N, R_NUM);
			7'd76: r = mk(OP_DIV, ACC_SET, R_NUM, R_DET, 5'd5);
			default: r = mk(OP_END, ACC_SET, R_N, R_N, R_N);
		endcase
		return r;
	endfunction

endpackage

### design/tcaf_if.sv
interface tcaf_touch_if;
	logic              valid;
	logic              ready;
	tcaf_pkg::touch_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tcaf_fit_if;
	logic            valid;
	logic            ready;
	tcaf_pkg::fit_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### design/tcaf_cfg.sv
module tcaf_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output tcaf_pkg::cfg_t      cfg
);

	logic [11:0] width_q;
	logic [11:0] height_q;
	logic [9:0]  margin_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd240;
			height_q <= 12'd320;
			margin_q <= 10'd50;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				tcaf_pkg::CFG_SCREEN_WIDTH:  width_q  <= pwdata[11:0];
				tcaf_pkg::CFG_SCREEN_HEIGHT: height_q <= pwdata[11:0];
				tcaf_pkg::CFG_TARGET_MARGIN: margin_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			tcaf_pkg::CFG_SCREEN_WIDTH:  prdata = {20'd0, width_q};
			tcaf_pkg::CFG_SCREEN_HEIGHT: prdata = {20'd0, height_q};
			tcaf_pkg::CFG_TARGET_MARGIN: prdata = {22'd0, margin_q};
			default:                     prdata = 32'd0;
		endcase
	end

	assign cfg.screen_width  = width_q;
	assign cfg.screen_height = height_q;
	assign cfg.target_margin = margin_q;

endmodule

### design/tcaf_dp.sv
module tcaf_dp #(
	parameter int RAW_BITS    = 12,
	parameter int SCALE_SHIFT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tcaf_pkg::dp_cmd_t  cmd,
	output tcaf_pkg::dp_sts_t  sts,
	input  tcaf_pkg::cfg_t     cfg,
	input  tcaf_pkg::touch_t   touch_data,
	output tcaf_pkg::fit_t     fit_data
);

	localparam int W    = 4 * RAW_BITS + SCALE_SHIFT + 32;
	localparam int OPW  = (RAW_BITS + 1 > 14) ? RAW_BITS + 1 : 14;
	localparam int OP2W = RAW_BITS + 1;
	localparam int TW   = OPW + OP2W;
	localparam int CNTW = $clog2(W + 1);
	localparam logic [31:0] SCALE_FULL = 32'd1 << SCALE_SHIFT;

	// stored pen samples
	logic [RAW_BITS-1:0] px_q [5];
	logic [RAW_BITS-1:0] py_q [5];
	logic [tcaf_pkg::RAW_MAX-1:0] rx_ext;
	logic [tcaf_pkg::RAW_MAX-1:0] ry_ext;

	assign rx_ext = {{(tcaf_pkg::RAW_MAX - tcaf_pkg::FIELD_BITS){1'b0}}, touch_data.raw_x};
	assign ry_ext = {{(tcaf_pkg::RAW_MAX - tcaf_pkg::FIELD_BITS){1'b0}}, touch_data.raw_y};

	always_ff @(posedge clk) begin
		if (cmd.store_pt) begin
			px_q[cmd.pt_idx] <= rx_ext[RAW_BITS-1:0];
			py_q[cmd.pt_idx] <= ry_ext[RAW_BITS-1:0];
		end
	end

	// register file, registered reads
	logic signed [W-1:0] rf_q [tcaf_pkg::NREGS];
	logic signed [W-1:0] ra_q;
	logic signed [W-1:0] rb_q;
	logic signed [W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			rf_q[cmd.wr_addr] <= acc_q;
		ra_q <= rf_q[cmd.rd_a];
		rb_q <= rf_q[cmd.rd_b];
	end

	// calibration targets of the current point
	logic signed [13:0] t_wm;
	logic signed [13:0] t_hm;
	logic signed [13:0] t_m;
	logic signed [13:0] tx;
	logic signed [13:0] ty;

	assign t_m  = $signed({4'd0, cfg.target_margin});
	assign t_wm = $signed({2'd0, cfg.screen_width}) - t_m;
	assign t_hm = $signed({2'd0, cfg.screen_height}) - t_m;

	always_comb begin
		unique case (cmd.pt_idx)
			3'd0: begin tx = t_m;  ty = t_m;  end
			3'd1: begin tx = t_wm; ty = t_m;  end
			3'd2: begin tx = t_wm; ty = t_hm; end
			3'd3: begin tx = t_m;  ty = t_hm; end
			3'd4: begin
				tx = $signed({3'd0, cfg.screen_width[11:1]});
				ty = $signed({3'd0, cfg.screen_height[11:1]});
			end
			default: begin tx = '0; ty = '0; end
		endcase
	end

	logic signed [OPW-1:0]  op1;
	logic signed [OP2W-1:0] op2;
	logic signed [TW-1:0]   tprod;
	logic [RAW_BITS-1:0]    cur_x;
	logic [RAW_BITS-1:0]    cur_y;

	assign cur_x = px_q[cmd.pt_idx];
	assign cur_y = py_q[cmd.pt_idx];

	always_comb begin
		case (cmd.rd_a)
			tcaf_pkg::SEL_ONE: op1 = OPW'(1);
			tcaf_pkg::SEL_RX:  op1 = OPW'(cur_x);
			tcaf_pkg::SEL_RY:  op1 = OPW'(cur_y);
			tcaf_pkg::SEL_TX:  op1 = OPW'(tx);
			tcaf_pkg::SEL_TY:  op1 = OPW'(ty);
			default:           op1 = '0;
		endcase
		case (cmd.rd_b)
			tcaf_pkg::SEL_ONE: op2 = OP2W'(1);
			tcaf_pkg::SEL_RX:  op2 = OP2W'(cur_x);
			tcaf_pkg::SEL_RY:  op2 = OP2W'(cur_y);
			default:           op2 = '0;
		endcase
	end

	assign tprod = op1 * op2;

	// shift-add multiplier on magnitudes
	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;
	logic [W-1:0] mcand_q;
	logic [W-1:0] mplier_q;
	logic [W-1:0] prod_q;
	logic         mneg_q;
	logic         mul_busy_q;
	logic         mul_done;
	logic signed [W-1:0] term_q;

	assign a_mag    = ra_q[W-1] ? $unsigned(-ra_q) : $unsigned(ra_q);
	assign b_mag    = rb_q[W-1] ? $unsigned(-rb_q) : $unsigned(rb_q);
	assign mul_done = mul_busy_q && (mplier_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mul_busy_q <= 1'b0;
		else if (cmd.mul_start)
			mul_busy_q <= 1'b1;
		else if (mul_done)
			mul_busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mcand_q  <= a_mag;
			mplier_q <= b_mag;
			prod_q   <= '0;
			mneg_q   <= ra_q[W-1] ^ rb_q[W-1];
		end else if (mul_busy_q && !mul_done) begin
			prod_q   <= prod_q + (mplier_q[0] ? mcand_q : '0);
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
		if (cmd.term_go)
			term_q <= W'(tprod);
		else if (mul_done)
			term_q <= mneg_q ? -$signed(prod_q) : $signed(prod_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_go) begin
			case (cmd.acc_mode)
				tcaf_pkg::ACC_SET: acc_q <= term_q;
				tcaf_pkg::ACC_ADD: acc_q <= acc_q + term_q;
				tcaf_pkg::ACC_SUB: acc_q <= acc_q - term_q;
				default:           acc_q <= acc_q;
			endcase
		end
	end

	// restoring divider, one quotient bit per cycle
	logic [W-1:0]    dvd_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    dsr_q;
	logic            qneg_q;
	logic [CNTW-1:0] div_cnt_q;
	logic            div_busy_q;
	logic [2:0]      div_idx_q;
	logic            div_done;
	logic [W:0]      rtry;
	logic [W:0]      rdiff;
	logic            qbit;
	logic [31:0]     qsat;
	logic            pos_ovf;
	logic            neg_ovf;
	logic signed [31:0] coef_q [6];

	assign div_done = div_busy_q && (div_cnt_q == '0);
	assign rtry     = {rem_q, dvd_q[W-1]};
	assign rdiff    = rtry - {1'b0, dsr_q};
	assign qbit     = !rdiff[W];

	assign pos_ovf = |dvd_q[W-1:31];
	assign neg_ovf = (|dvd_q[W-1:32]) || (dvd_q[31] && (|dvd_q[30:0]));

	always_comb begin
		if (!qneg_q)
			qsat = pos_ovf ? 32'h7FFF_FFFF : dvd_q[31:0];
		else
			qsat = neg_ovf ? 32'h8000_0000 : 32'd0 - dvd_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= CNTW'(W);
		end else if (div_done) begin
			div_busy_q <= 1'b0;
		end else if (div_busy_q) begin
			div_cnt_q  <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q     <= a_mag << SCALE_SHIFT;
			dsr_q     <= b_mag;
			rem_q     <= '0;
			qneg_q    <= ra_q[W-1] ^ rb_q[W-1];
			div_idx_q <= cmd.coef_idx;
		end else if (div_busy_q && !div_done) begin
			rem_q <= qbit ? rdiff[W-1:0] : rtry[W-1:0];
			dvd_q <= {dvd_q[W-2:0], qbit};
		end
		if (div_done)
			coef_q[div_idx_q] <= $signed(qsat);
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			fit_data.fit_ok      <= cmd.out_ok;
			fit_data.xs_offset   <= cmd.out_ok ? coef_q[0] : '0;
			fit_data.xs_from_rx  <= cmd.out_ok ? coef_q[1] : '0;
			fit_data.xs_from_ry  <= cmd.out_ok ? coef_q[2] : '0;
			fit_data.ys_offset   <= cmd.out_ok ? coef_q[3] : '0;
			fit_data.ys_from_rx  <= cmd.out_ok ? coef_q[4] : '0;
			fit_data.ys_from_ry  <= cmd.out_ok ? coef_q[5] : '0;
			fit_data.scale_value <= SCALE_FULL[16:0];
		end
	end

	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;
	assign sts.acc_zero = (acc_q == '0);

endmodule

### design/tcaf_ctrl.sv
`include "touch_calibration_affine_fit_top_assert.svh"

module tcaf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  tcaf_pkg::dp_sts_t  sts,
	output tcaf_pkg::dp_cmd_t  cmd
);

	tcaf_pkg::state_t state_q, state_d;
	logic [6:0] pc_q, pc_d;
	logic [2:0] cnt_q, cnt_d;
	logic [2:0] j_q, j_d;
	logic       ok_q, ok_d;
	logic       out_valid_q;
	tcaf_pkg::instr_t instr;

	assign instr     = tcaf_pkg::prog_at(pc_q);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcaf_pkg::ST_COLLECT;
			pc_q        <= '0;
			cnt_q       <= '0;
			j_q         <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			cnt_q   <= cnt_d;
			j_q     <= j_d;
			ok_q    <= ok_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		pc_d     = pc_q;
		cnt_d    = cnt_q;
		j_d      = j_q;
		ok_d     = ok_q;
		in_ready = 1'b0;
		cmd          = '0;
		cmd.rd_a     = instr.a;
		cmd.rd_b     = instr.b;
		cmd.wr_addr  = instr.d;
		cmd.coef_idx = instr.d[2:0];
		cmd.pt_idx   = (state_q == tcaf_pkg::ST_COLLECT) ? cnt_q : j_q;
		cmd.acc_mode = (instr.op == tcaf_pkg::OP_SUMPT) ?
			((j_q == 3'd0) ? tcaf_pkg::ACC_SET : tcaf_pkg::ACC_ADD) : instr.mode;

		unique case (state_q)
			tcaf_pkg::ST_COLLECT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.store_pt = 1'b1;
					if (cnt_q == 3'd4) begin
						cnt_d   = '0;
						pc_d    = '0;
						state_d = tcaf_pkg::ST_DISPATCH;
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
			end
			tcaf_pkg::ST_DISPATCH: begin
				unique case (instr.op)
					tcaf_pkg::OP_SUMPT: begin
						j_d     = '0;
						state_d = tcaf_pkg::ST_START;
					end
					tcaf_pkg::OP_MUL, tcaf_pkg::OP_DIV: state_d = tcaf_pkg::ST_START;
					tcaf_pkg::OP_STORE: begin
						cmd.wr_en = 1'b1;
						pc_d      = pc_q + 7'd1;
					end
					tcaf_pkg::OP_ZCHK: begin
						if (sts.acc_zero) begin
							ok_d    = 1'b0;
							state_d = tcaf_pkg::ST_EMIT;
						end else begin
							pc_d = pc_q + 7'd1;
						end
					end
					default: begin
						ok_d    = (instr.op == tcaf_pkg::OP_END);
						state_d = tcaf_pkg::ST_EMIT;
					end
				endcase
			end
			tcaf_pkg::ST_START: begin
				unique case (instr.op)
					tcaf_pkg::OP_SUMPT: begin
						cmd.term_go = 1'b1;
						state_d     = tcaf_pkg::ST_ACCUM;
					end
					tcaf_pkg::OP_MUL: begin
						cmd.mul_start = 1'b1;
						state_d       = tcaf_pkg::ST_BUSY;
					end
					tcaf_pkg::OP_DIV: begin
						cmd.div_start = 1'b1;
						state_d       = tcaf_pkg::ST_BUSY;
					end
					default: state_d = tcaf_pkg::ST_DISPATCH;
				endcase
			end
			tcaf_pkg::ST_BUSY: begin
				if (instr.op == tcaf_pkg::OP_MUL) begin
					if (sts.mul_done)
						state_d = tcaf_pkg::ST_ACCUM;
				end else if (sts.div_done) begin
					pc_d    = pc_q + 7'd1;
					state_d = tcaf_pkg::ST_DISPATCH;
				end
			end
			tcaf_pkg::ST_ACCUM: begin
				cmd.acc_go = 1'b1;
				if (instr.op == tcaf_pkg::OP_SUMPT && j_q != 3'd4) begin
					j_d     = j_q + 3'd1;
					state_d = tcaf_pkg::ST_START;
				end else begin
					pc_d    = pc_q + 7'd1;
					state_d = tcaf_pkg::ST_DISPATCH;
				end
			end
			tcaf_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.out_ok   = ok_q;
					state_d      = tcaf_pkg::ST_COLLECT;
				end
			end
			default: state_d = tcaf_pkg::ST_COLLECT;
		endcase
	end

	`TCAF_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= 3'd4)
	`TCAF_ASSERT_IMP(a_pc_range, 1'b1, pc_q <= tcaf_pkg::PROG_LAST)
	`TCAF_ASSERT_IMP(a_load_free, cmd.out_load, !out_valid_q || out_ready)
	`TCAF_ASSERT_NXT(a_fifth_starts, in_ready && in_valid && cnt_q == 3'd4, state_q == tcaf_pkg::ST_DISPATCH && pc_q == 7'd0)

endmodule

### design/touch_calibration_affine_fit_top.sv
// Five-point touchscreen calibration. Each transaction on touch is one pen release and is
// taken as soon as it is offered during collection; targets are top-left, top-right,
// bottom-right, bottom-left (corners inset by target_margin) then the screen center. After
// the fifth sample touch stalls while a 78-step sequence runs on one shift-add multiplier
// and one restoring divider: 33 multiplies, each iterating over the bits of its second
// operand, and six divisions; when the determinant is zero the sequence stops after it.
// One fit transaction then appears on fit, with fit_ok low and zero coefficients when the
// determinant is zero, and collection restarts; the result register lets collection go on
// while it waits. Coefficients are scaled by 2^SCALE_SHIFT, truncated toward zero and
// saturated to 32 bits. Configuration registers at byte addresses 0, 4, 8 should be written
// only while idle.
module touch_calibration_affine_fit_top #(
	parameter int RAW_BITS    = 12,
	parameter int SCALE_SHIFT = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tcaf_touch_if.sink    touch,
	tcaf_fit_if.source    fit,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	tcaf_pkg::cfg_t    cfg;
	tcaf_pkg::dp_cmd_t cmd;
	tcaf_pkg::dp_sts_t sts;

	tcaf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcaf_dp #(
		.RAW_BITS    (RAW_BITS),
		.SCALE_SHIFT (SCALE_SHIFT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg        (cfg),
		.touch_data (touch.data),
		.fit_data   (fit.data)
	);

	tcaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (touch.valid),
		.in_ready  (touch.ready),
		.out_valid (fit.valid),
		.out_ready (fit.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

endmodule
